// ===== hw/rtl/kla_pkg.sv =====
// ----------------------------------------------------------------------------
// kla_pkg
// Shared widths, types and the log2 table generator for the KL divergence
// accumulator.
// ----------------------------------------------------------------------------
package kla_pkg;

    localparam int LOG_TABLE_BITS_DEF = 6;

    localparam int PROB_W = 17;
    localparam int FRAC_W = 16;
    localparam int EXP_W  = 5;
    localparam int TBL_W  = FRAC_W + 1;
    localparam int LOG_W  = 22;
    localparam int DIFF_W = LOG_W + 1;
    localparam int PROD_W = PROB_W + 1 + DIFF_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int SUM_W  = 34;

    typedef logic        [PROB_W-1:0] t_prob;
    typedef logic signed [LOG_W-1:0]  t_log;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_sum SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // log2(1 + k / 2^tbits) in Q.16 by repeated squaring, elaboration only
    function automatic logic [TBL_W-1:0] frac_log2(input int unsigned k,
                                                   input int unsigned tbits);
        logic [63:0]      m;
        logic [FRAC_W:0]  bits;
        logic [FRAC_W+1:0] rnd;
        m    = (64'd1 << 31) + (64'(k) << (31 - tbits));
        bits = '0;
        for (int i = 0; i < FRAC_W + 1; i++) begin
            m    = (m * m) >> 31;
            bits = bits << 1;
            if (m >= (64'd1 << 32)) begin
                bits[0] = 1'b1;
                m       = m >> 1;
            end
        end
        rnd = {1'b0, bits} + (FRAC_W+2)'(1);
        return rnd[FRAC_W+1:1];
    endfunction

endpackage

// ===== hw/rtl/kl_divergence_accumulator.sv =====
// ----------------------------------------------------------------------------
// kl_divergence_accumulator
// Streaming base-2 Kullback-Leibler divergence of two Q1.16 distributions.
// ----------------------------------------------------------------------------
// One pair (p, q) is taken per request at up to one per clock. Each pair
// adds floor(p * (log2 p - log2 q) / 65536) to a saturating 34-bit Q.16
// sum; log2 comes from the leading-one position and a 2^LOG_TABLE_BITS
// entry fraction table, with log2 of zero taken as 0. The request marked
// last emits the sum including its own term and clears the accumulator.
// The datapath has four registers in line: input, log difference, product
// term and accumulator/result. The only stall comes from a held result:
// while a result waits, non-last requests keep flowing into the accumulator
// and a following last request waits in the term stage.
// ----------------------------------------------------------------------------
module kl_divergence_accumulator #(
    parameter int LOG_TABLE_BITS = kla_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [kla_pkg::PROB_W-1:0]   i_p_first,
    input  logic [kla_pkg::PROB_W-1:0]   i_p_second,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [kla_pkg::SUM_W-1:0] o_divergence
);
    import kla_pkg::*;

    localparam int TBL_SIZE = 1 << LOG_TABLE_BITS;
    localparam int SHF_W    = PROB_W + LOG_TABLE_BITS;

    // fraction table
    logic [TBL_W-1:0] w_tbl [TBL_SIZE];

    for (genvar g = 0; g < TBL_SIZE; g++) begin : g_tbl
        assign w_tbl[g] = frac_log2(g, LOG_TABLE_BITS);
    end

    // pipeline registers
    logic  r_v1, r_v2, r_v3, r_out_valid;
    t_prob r_p, r_q, r_p2;
    logic  r_last, r_last2, r_last3;
    t_diff r_d;
    t_term r_term;
    t_sum  r_acc, r_out;

    logic  n_adv3, n_rdy3, n_rdy2, n_rdy1;

    // stage 1: log2 of both operands and their difference
    t_prob                     w_x   [2];
    logic  [EXP_W-1:0]         w_e   [2];
    logic  [SHF_W-1:0]         w_shf [2];
    logic  [LOG_TABLE_BITS-1:0] w_idx [2];
    logic  signed [5:0]        w_ed  [2];
    t_log                      w_log [2];
    t_diff                     n_d;

    assign w_x[0] = r_p;
    assign w_x[1] = r_q;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            w_e[j] = '0;
            for (int i = 0; i < PROB_W; i++) begin
                if (w_x[j][i]) begin
                    w_e[j] = EXP_W'(i);
                end
            end
            w_shf[j] = {w_x[j], {LOG_TABLE_BITS{1'b0}}} >> w_e[j];
            w_idx[j] = w_shf[j][LOG_TABLE_BITS-1:0];
            w_ed[j]  = $signed({1'b0, w_e[j]}) - 6'sd16;
            if (w_x[j] == '0) begin
                w_log[j] = '0;
            end else begin
                w_log[j] = $signed({w_ed[j], {FRAC_W{1'b0}}})
                         + $signed({{(LOG_W-TBL_W){1'b0}}, w_tbl[w_idx[j]]});
            end
        end
        n_d = DIFF_W'(w_log[0]) - DIFF_W'(w_log[1]);
    end

    // stage 2: weighted term, floor shift by 16
    logic signed [PROD_W-1:0] w_prod;
    assign w_prod = $signed({1'b0, r_p2}) * r_d;

    // stage 3: saturating accumulate
    logic signed [SUM_W:0] w_sum;
    t_sum                  w_sat;

    always_comb begin
        w_sum = (SUM_W+1)'(r_acc) + (SUM_W+1)'(r_term);
        if (w_sum[SUM_W] != w_sum[SUM_W-1]) begin
            w_sat = w_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sat = w_sum[SUM_W-1:0];
        end
    end

    // flow control
    always_comb begin
        n_adv3 = r_v3 && (!r_last3 || !r_out_valid || !i_stall);
        n_rdy3 = !r_v3 || n_adv3;
        n_rdy2 = !r_v2 || n_rdy3;
        n_rdy1 = !r_v1 || n_rdy2;
    end

    assign o_stall = !n_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            if (n_rdy1) begin
                r_v1 <= i_valid;
            end
            if (n_rdy2) begin
                r_v2 <= r_v1;
            end
            if (n_rdy3) begin
                r_v3 <= r_v2;
            end
            if (n_adv3) begin
                r_acc <= r_last3 ? '0 : w_sat;
            end
            if (n_adv3 && r_last3) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy1) begin
            r_p    <= i_p_first;
            r_q    <= i_p_second;
            r_last <= i_last;
        end
        if (n_rdy2) begin
            r_p2    <= r_p;
            r_d     <= n_d;
            r_last2 <= r_last;
        end
        if (n_rdy3) begin
            r_term  <= w_prod[PROD_W-1:FRAC_W];
            r_last3 <= r_last2;
        end
        if (n_adv3 && r_last3) begin
            r_out <= w_sat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_divergence = r_out;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_adv3 && r_last3) |=> (r_acc == '0))
        else $error("accumulator not cleared after last request");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(n_adv3 && r_last3))
        else $error("result raised without a last request");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_last3 && r_out_valid && i_stall) |=> (r_v3 && r_last3))
        else $error("last request dropped while result held");

    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_adv3 |=> $stable(r_acc))
        else $error("accumulator changed without a retiring request");
`endif

endmodule
